// ===== hdl/lhu_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package lhu_pkg;

  localparam int unsigned BUCKETS = 64;
  localparam int unsigned IDX_W   = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  // Walk counter must also hold BUCKETS itself.
  localparam int unsigned CNT_W   = $clog2(BUCKETS + 1);
  localparam int unsigned FRAC_W  = 17;
  localparam logic [FRAC_W-1:0] Q16_ONE = FRAC_W'(65536);

  typedef enum logic [1:0] {
    CMD_RECORD = 2'd0,
    CMD_QUERY  = 2'd1,
    CMD_CLEAR  = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_REC,
    ST_WALK
  } state_e;

  typedef struct packed {
    logic [1:0]        command;
    logic [63:0]       sample;
    logic [FRAC_W-1:0] pct_fraction;
  } in_t;

  typedef struct packed {
    logic [63:0] percentile_value;
    logic [63:0] total_count;
    logic [63:0] total_sum;
    logic [63:0] min_seen;
    logic [63:0] max_seen;
  } res_t;

  typedef struct packed {
    logic             clear;
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    logic [63:0]      wr_data;
  } mem_req_t;

  // Index of the highest set bit, zero for zero, clamped to the last bucket.
  function automatic logic [IDX_W-1:0] bucket_of(logic [63:0] v);
    int unsigned msb;
    msb = 0;
    for (int unsigned b = 0; b < 64; b++) begin
      if (v[b]) begin
        msb = b;
      end
    end
    if (msb > BUCKETS - 1) begin
      msb = BUCKETS - 1;
    end
    return IDX_W'(msb);
  endfunction

  function automatic logic [63:0] midpoint(logic [IDX_W-1:0] i);
    logic [63:0] r;
    if (i == '0) begin
      r = 64'd1;
    end else begin
      r = (64'd1 << i) + (64'd1 << (i - IDX_W'(1)));
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/log2_latency_histogram_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Record: the start transfer reads the bucket RAM, then ST_REC increments and writes back
//   the bucket and registers the strobe; busy in ST_REC, so records do not overlap.
// Query: a walk in ST_WALK, one bucket read per cycle from the RAM port.
// Clear, a query on an empty histogram and the unused code: strobe in the cycle after the start.
// Reset clears the counters and the bucket valid bits at once; no clearing pass.
// The receiver cannot stall: each result is shown for exactly one cycle.
module log2_latency_histogram_unit (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         start,
  input  wire lhu_pkg::in_t item_i,
  output logic              busy,
  output logic              result_valid_o,
  output lhu_pkg::res_t     res_o
);

  lhu_pkg::state_e state_q, state_d;
  lhu_pkg::mem_req_t mreq;
  lhu_pkg::res_t res_q, res_d;

  logic [63:0] count_q, count_d;
  logic [63:0] sum_q, sum_d;
  logic [63:0] min_q, min_d;
  logic [63:0] max_q, max_d;
  logic [63:0] thr_q, thr_d;
  logic [63:0] run_q, run_d;
  logic [lhu_pkg::CNT_W-1:0] addr_q, addr_d;
  logic [lhu_pkg::IDX_W-1:0] widx_q, widx_d;
  logic [lhu_pkg::IDX_W-1:0] rec_idx_q, rec_idx_d;
  logic [63:0] rec_val_q, rec_val_d;
  logic pend_q, pend_d;
  logic done_q, done_d;

  logic        accept;
  logic [63:0] rd_word;
  logic [63:0] run_sum;
  logic        hit;
  logic        last;
  logic        addr_live;
  logic [lhu_pkg::FRAC_W-1:0] frac_sat;
  logic [64:0] hi_prod;
  logic [32:0] lo_prod;
  logic [63:0] threshold;
  logic [lhu_pkg::IDX_W-1:0] in_idx;

  lhu_bucket_mem u_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (mreq),
    .rd_word_o (rd_word)
  );

  assign accept    = start && !busy;
  assign busy      = (state_q != lhu_pkg::ST_IDLE);
  assign in_idx    = lhu_pkg::bucket_of(item_i.sample);

  assign frac_sat  = (item_i.pct_fraction > lhu_pkg::Q16_ONE) ? lhu_pkg::Q16_ONE
                                                              : item_i.pct_fraction;
  // Split the count so the product never overflows 64 bits.
  assign hi_prod   = 65'(count_q[63:16]) * 65'(frac_sat);
  assign lo_prod   = 33'(count_q[15:0]) * 33'(frac_sat);
  assign threshold = hi_prod[63:0] + 64'(lo_prod[32:16]);

  assign run_sum   = run_q + rd_word;
  assign hit       = pend_q && (run_sum >= thr_q);
  assign last      = pend_q && (widx_q == lhu_pkg::IDX_W'(lhu_pkg::BUCKETS - 1));
  assign addr_live = (addr_q < lhu_pkg::CNT_W'(lhu_pkg::BUCKETS));

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      lhu_pkg::ST_IDLE: begin
        if (accept) begin
          if (item_i.command == lhu_pkg::CMD_RECORD) begin
            state_d = lhu_pkg::ST_REC;
          end else if (item_i.command == lhu_pkg::CMD_QUERY && count_q != 64'd0) begin
            state_d = lhu_pkg::ST_WALK;
          end
        end
      end
      lhu_pkg::ST_REC: begin
        state_d = lhu_pkg::ST_IDLE;
      end
      lhu_pkg::ST_WALK: begin
        if (hit || last) begin
          state_d = lhu_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = lhu_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    count_d   = count_q;
    sum_d     = sum_q;
    min_d     = min_q;
    max_d     = max_q;
    thr_d     = thr_q;
    run_d     = run_q;
    addr_d    = addr_q;
    widx_d    = widx_q;
    pend_d    = 1'b0;
    rec_idx_d = rec_idx_q;
    rec_val_d = rec_val_q;
    res_d     = res_q;
    done_d    = 1'b0;
    mreq      = '0;

    unique case (state_q)
      lhu_pkg::ST_IDLE: begin
        if (accept) begin
          unique case (item_i.command)
            lhu_pkg::CMD_RECORD: begin
              mreq.rd_en   = 1'b1;
              mreq.rd_addr = in_idx;
              rec_idx_d    = in_idx;
              rec_val_d    = item_i.sample;
            end
            lhu_pkg::CMD_QUERY: begin
              if (count_q == 64'd0) begin
                res_d  = '{64'd0, count_q, sum_q, min_q, max_q};
                done_d = 1'b1;
              end else begin
                thr_d  = threshold;
                run_d  = 64'd0;
                addr_d = '0;
              end
            end
            lhu_pkg::CMD_CLEAR: begin
              mreq.clear = 1'b1;
              count_d    = 64'd0;
              sum_d      = 64'd0;
              min_d      = '1;
              max_d      = 64'd0;
              res_d      = '{64'd0, 64'd0, 64'd0, '1, 64'd0};
              done_d     = 1'b1;
            end
            default: begin
              res_d  = '{64'd0, count_q, sum_q, min_q, max_q};
              done_d = 1'b1;
            end
          endcase
        end
      end
      lhu_pkg::ST_REC: begin
        mreq.wr_en   = 1'b1;
        mreq.wr_addr = rec_idx_q;
        mreq.wr_data = rd_word + 64'd1;
        count_d      = count_q + 64'd1;
        sum_d        = sum_q + rec_val_q;
        min_d        = (rec_val_q < min_q) ? rec_val_q : min_q;
        max_d        = (rec_val_q > max_q) ? rec_val_q : max_q;
        res_d        = '{64'd0, count_d, sum_d, min_d, max_d};
        done_d       = 1'b1;
      end
      lhu_pkg::ST_WALK: begin
        // Reads run one bucket ahead of the running-total compare.
        if (addr_live) begin
          mreq.rd_en   = 1'b1;
          mreq.rd_addr = addr_q[lhu_pkg::IDX_W-1:0];
          addr_d       = addr_q + lhu_pkg::CNT_W'(1);
          widx_d       = addr_q[lhu_pkg::IDX_W-1:0];
          pend_d       = 1'b1;
        end
        if (pend_q) begin
          run_d = run_sum;
        end
        if (hit) begin
          res_d  = '{lhu_pkg::midpoint(widx_q), count_q, sum_q, min_q, max_q};
          done_d = 1'b1;
        end else if (last) begin
          res_d  = '{max_q, count_q, sum_q, min_q, max_q};
          done_d = 1'b1;
        end
      end
      default: begin
        done_d = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lhu_pkg::ST_IDLE;
      count_q <= 64'd0;
      sum_q   <= 64'd0;
      min_q   <= '1;
      max_q   <= 64'd0;
      addr_q  <= '0;
      pend_q  <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      sum_q   <= sum_d;
      min_q   <= min_d;
      max_q   <= max_d;
      addr_q  <= addr_d;
      pend_q  <= pend_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    thr_q     <= thr_d;
    run_q     <= run_d;
    widx_q    <= widx_d;
    rec_idx_q <= rec_idx_d;
    rec_val_q <= rec_val_d;
    res_q     <= res_d;
  end

  assign result_valid_o = done_q;
  assign res_o          = res_q;

endmodule

`default_nettype wire

// ===== hdl/lhu_bucket_mem.sv =====
`timescale 1ns / 1ps
`default_nettype none

module lhu_bucket_mem (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire lhu_pkg::mem_req_t req_i,
  output logic [63:0]            rd_word_o
);

  logic [63:0]                mem_q [lhu_pkg::BUCKETS];
  logic [lhu_pkg::BUCKETS-1:0] valid_q;
  logic [63:0]                rd_data_q;
  logic                       rd_vld_q;

  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem_q[req_i.wr_addr] <= req_i.wr_data;
    end
    if (req_i.rd_en) begin
      rd_data_q <= mem_q[req_i.rd_addr];
    end
  end

  // Valid bits stand in for clearing the array: an entry never written since
  // the last clear reads as zero.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (req_i.rd_en) begin
        rd_vld_q <= valid_q[req_i.rd_addr];
      end
      if (req_i.clear) begin
        valid_q <= '0;
      end else if (req_i.wr_en) begin
        valid_q[req_i.wr_addr] <= 1'b1;
      end
    end
  end

  assign rd_word_o = rd_vld_q ? rd_data_q : 64'd0;

endmodule

`default_nettype wire
